FILE: hdl/lctp_pkg.sv
`default_nettype none

package lctp_pkg;

  localparam int unsigned MaxLeds    = 32;
  localparam int unsigned ColorCount = 16;
  localparam int unsigned ChunkMax   = 10;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned FlagW  = 6;
  localparam int unsigned FuncW  = 3;
  localparam int unsigned LenW   = 4;

  localparam logic [ByteW-1:0] MaxLedsC    = ByteW'(MaxLeds);
  localparam logic [ByteW-1:0] ColorCountC = ByteW'(ColorCount);
  localparam logic [LenW-1:0]  ChunkMaxC   = LenW'(ChunkMax);

  localparam logic [CharW-1:0] ChComma = 8'h2C;
  localparam logic [CharW-1:0] ChColon = 8'h3A;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChTerm  = 8'h00;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 48;

  typedef enum logic [2:0] {
    PH_X     = 3'd0,
    PH_Y     = 3'd1,
    PH_DIRS  = 3'd2,
    PH_FUNCS = 3'd3,
    PH_COLOR = 3'd4
  } phase_e;

  typedef struct packed {
    logic             is_term;
    logic             is_comma;
    logic             is_colon;
    logic             is_digit;
    logic [3:0]       digit;
    logic [FlagW-1:0] dir_mask;
    logic             func_hit;
    logic [FuncW-1:0] func_idx;
    logic [FlagW-1:0] ovl_mask;
  } char_class_t;

  typedef struct packed {
    logic             ok;
    logic [ByteW-1:0] slot;
    logic [ByteW-1:0] pos_x;
    logic [ByteW-1:0] pos_y;
    logic [FlagW-1:0] dir_flags;
    logic [FuncW-1:0] base_func;
    logic [FlagW-1:0] overlay_bits;
    logic [ByteW-1:0] color_index;
  } led_result_t;

  function automatic logic [CharW-1:0] dir_letter(input logic [2:0] i);
    logic [CharW-1:0] r;
    case (i)
      3'd0:    r = 8'h4E; // N
      3'd1:    r = 8'h45; // E
      3'd2:    r = 8'h53; // S
      3'd3:    r = 8'h57; // W
      3'd4:    r = 8'h55; // U
      3'd5:    r = 8'h44; // D
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [CharW-1:0] func_letter(input logic [2:0] i);
    logic [CharW-1:0] r;
    case (i)
      3'd0:    r = 8'h43; // C
      3'd1:    r = 8'h46; // F
      3'd2:    r = 8'h41; // A
      3'd3:    r = 8'h4C; // L
      3'd4:    r = 8'h53; // S
      3'd5:    r = 8'h47; // G
      3'd6:    r = 8'h52; // R
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [CharW-1:0] ovl_letter(input logic [2:0] i);
    logic [CharW-1:0] r;
    case (i)
      3'd0:    r = 8'h54; // T
      3'd1:    r = 8'h4F; // O
      3'd2:    r = 8'h42; // B
      3'd3:    r = 8'h4E; // N
      3'd4:    r = 8'h49; // I
      3'd5:    r = 8'h57; // W
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/lctp_char_decode.sv
`default_nettype none

module lctp_char_decode (
  input  logic [lctp_pkg::CharW-1:0] char_i,
  output lctp_pkg::char_class_t      class_o
);
  import lctp_pkg::*;

  always_comb begin
    class_o          = '0;
    class_o.is_term  = (char_i == ChTerm);
    class_o.is_comma = (char_i == ChComma);
    class_o.is_colon = (char_i == ChColon);
    class_o.is_digit = (char_i >= ChZero) && (char_i <= ChNine);
    class_o.digit    = 4'(char_i - ChZero);
    for (int i = 0; i < FlagW; i++) begin
      class_o.dir_mask[i] = (char_i == dir_letter(3'(i)));
      class_o.ovl_mask[i] = (char_i == ovl_letter(3'(i)));
    end
    for (int i = 0; i < 7; i++) begin
      if (char_i == func_letter(3'(i))) begin
        class_o.func_hit = 1'b1;
        class_o.func_idx = 3'(i);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lctp_parser.sv
`default_nettype none

module lctp_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  lctp_pkg::char_class_t      class_i,
  input  logic [lctp_pkg::ByteW-1:0] index_i,
  output logic                       res_valid_o,
  output lctp_pkg::led_result_t      res_o
);
  import lctp_pkg::*;

  phase_e           phase_q, phase_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [ByteW-1:0] accum_q, accum_d;
  logic             ended_q, ended_d;
  logic [ByteW-1:0] x_q, x_d;
  logic [ByteW-1:0] y_q, y_d;
  logic [FlagW-1:0] dir_q, dir_d;
  logic [FuncW-1:0] func_q, func_d;
  logic [FlagW-1:0] ovl_q, ovl_d;
  logic             err_q, err_d;
  logic [ByteW-1:0] held_q, held_d;
  logic             started_q, started_d;

  logic [ByteW-1:0] slot;
  logic             is_sep;
  logic [11:0]      acc_next;
  logic             ok;

  always_comb begin
    slot     = started_q ? held_q : index_i;
    acc_next = 12'(accum_q) * 12'd10 + 12'(class_i.digit);
    unique case (phase_q)
      PH_X:              is_sep = class_i.is_comma;
      PH_Y, PH_DIRS,
      PH_FUNCS:          is_sep = class_i.is_colon;
      default:           is_sep = 1'b0;
    endcase
    ok = !err_q && (phase_q == PH_COLOR) && (slot < MaxLedsC);

    res_o               = '0;
    res_o.slot          = slot;
    if (ok) begin
      res_o.ok            = 1'b1;
      res_o.pos_x         = x_q;
      res_o.pos_y         = y_q;
      res_o.dir_flags     = dir_q;
      res_o.base_func     = func_q;
      res_o.overlay_bits  = ovl_q;
      res_o.color_index   = (accum_q >= ColorCountC) ? '0 : accum_q;
    end
    res_valid_o = step_i && class_i.is_term;

    phase_d   = phase_q;
    len_d     = len_q;
    accum_d   = accum_q;
    ended_d   = ended_q;
    x_d       = x_q;
    y_d       = y_q;
    dir_d     = dir_q;
    func_d    = func_q;
    ovl_d     = ovl_q;
    err_d     = err_q;
    held_d    = held_q;
    started_d = started_q;

    if (step_i) begin
      held_d    = slot;
      started_d = 1'b1;
      if (class_i.is_term) begin
        phase_d   = PH_X;
        len_d     = '0;
        accum_d   = '0;
        ended_d   = 1'b0;
        x_d       = '0;
        y_d       = '0;
        dir_d     = '0;
        func_d    = '0;
        ovl_d     = '0;
        err_d     = 1'b0;
        held_d    = '0;
        started_d = 1'b0;
      end else if (err_q) begin
        // drop bytes until the terminator
      end else if (is_sep) begin
        if (phase_q == PH_X) x_d = accum_q;
        if (phase_q == PH_Y) y_d = accum_q;
        phase_d = phase_e'(phase_q + 3'd1);
        len_d   = '0;
        accum_d = '0;
        ended_d = 1'b0;
      end else if (len_q >= ChunkMaxC) begin
        err_d = 1'b1;
      end else begin
        len_d = len_q + LenW'(1);
        unique case (phase_q)
          PH_X, PH_Y, PH_COLOR: begin
            if (!ended_q) begin
              if (!class_i.is_digit) begin
                ended_d = 1'b1;
              end else begin
                accum_d = (acc_next > 12'd255) ? 8'hFF : acc_next[ByteW-1:0];
              end
            end
          end
          PH_DIRS: dir_d = dir_q | class_i.dir_mask;
          PH_FUNCS: begin
            if (class_i.func_hit) func_d = class_i.func_idx;
            ovl_d = ovl_q | class_i.ovl_mask;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_X;
      len_q     <= '0;
      accum_q   <= '0;
      ended_q   <= 1'b0;
      x_q       <= '0;
      y_q       <= '0;
      dir_q     <= '0;
      func_q    <= '0;
      ovl_q     <= '0;
      err_q     <= 1'b0;
      held_q    <= '0;
      started_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      len_q     <= len_d;
      accum_q   <= accum_d;
      ended_q   <= ended_d;
      x_q       <= x_d;
      y_q       <= y_d;
      dir_q     <= dir_d;
      func_q    <= func_d;
      ovl_q     <= ovl_d;
      err_q     <= err_d;
      held_q    <= held_d;
      started_q <= started_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/led_config_text_parser_top.sv
`default_nettype none

// Channel | Dir | Signals                      | Payload
// s_axis  | in  | tvalid tready tdata[15:0]    | char_byte, led_index
// m_axis  | out | tvalid tready tdata[47:0]    | slot, pos_x, pos_y, dir_flags,
//         |     | tuser[0]                     |   base_func, overlay_bits, color_index; ok
//
// One beat per cycle: each character passes an input register, the parsing
// logic and, on the terminator, the result register. m_axis_tvalid rises when
// the result register takes the parsed result of the terminator beat.
// Reset clears all record state; the first beat after reset starts a record.
// A held result stalls parsing until it is taken; otherwise input keeps flowing.

module led_config_text_parser_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] char_byte, [15:8] led_index
  input  logic [lctp_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] slot, [15:8] pos_x, [23:16] pos_y, [29:24] dir_flags,
  // [32:30] base_func, [38:33] overlay_bits, [46:39] color_index, [47] zero
  output logic [lctp_pkg::OutDataW-1:0] m_axis_tdata,
  // [0] ok
  output logic                          m_axis_tuser
);
  import lctp_pkg::*;

  logic             in_valid_q;
  logic [CharW-1:0] char_q;
  logic [ByteW-1:0] index_q;
  logic             out_valid_q;
  led_result_t      out_q;
  logic             out_free;
  logic             step;
  char_class_t      cls;
  logic             res_valid;
  led_result_t      res;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      char_q  <= s_axis_tdata[7:0];
      index_q <= s_axis_tdata[15:8];
    end
  end

  lctp_char_decode u_decode (
    .char_i  (char_q),
    .class_o (cls)
  );

  lctp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .class_i     (cls),
    .index_i     (index_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.ok;
  assign m_axis_tdata  = {1'b0, out_q.color_index, out_q.overlay_bits, out_q.base_func,
                          out_q.dir_flags, out_q.pos_y, out_q.pos_x, out_q.slot};

endmodule

`default_nettype wire

FILE: verif/led_config_text_parser_top_test.sv
`timescale 1ns / 100ps

module led_config_text_parser_top_test;
  import lctp_pkg::*;

  localparam logic [47:0] DirChars  = "NESWUD";
  localparam logic [55:0] FuncChars = "CFALSGR";
  localparam logic [47:0] OvlChars  = "TOBNIW";
  localparam int          BeatsPerPhase = 500;
  localparam int          SendIdlePct [4] = '{0, 68, 0, 30};
  localparam int          RecvStallPct[4] = '{0, 0, 68, 30};

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  logic [InDataW-1:0] beat_q[$];
  logic [CharW-1:0]   rec_buf[$];
  led_result_t        result_q[$];
  int                 beats_pushed   = 0;
  int                 beats_taken    = 0;
  int                 mismatch_count = 0;
  int                 send_idle_pct  = 0;
  int                 recv_stall_pct = 0;
  logic               beat_taken     = 1'b0;

  phase_e           parse_phase = PH_X;
  int               chunk_len   = 0;
  logic [ByteW-1:0] num_acc     = '0;
  logic             num_done    = 1'b0;
  logic [ByteW-1:0] x_hold      = '0;
  logic [ByteW-1:0] y_hold      = '0;
  logic [FlagW-1:0] dir_acc     = '0;
  logic [FuncW-1:0] func_acc    = '0;
  logic [FlagW-1:0] ovl_acc     = '0;
  logic             rec_failed  = 1'b0;
  logic [ByteW-1:0] slot_hold   = '0;
  logic             rec_open    = 1'b0;

  led_config_text_parser_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic void parse_char(logic [CharW-1:0] ch, logic [ByteW-1:0] idx);
    led_result_t res;
    int          v;
    if (!rec_open) begin
      slot_hold = idx;
      rec_open  = 1'b1;
    end
    if (ch == ChTerm) begin
      res      = '0;
      res.slot = slot_hold;
      if (!rec_failed && parse_phase == PH_COLOR && slot_hold < MaxLedsC) begin
        res.ok            = 1'b1;
        res.pos_x         = x_hold;
        res.pos_y         = y_hold;
        res.dir_flags     = dir_acc;
        res.base_func     = func_acc;
        res.overlay_bits  = ovl_acc;
        res.color_index   = (num_acc >= ColorCountC) ? '0 : num_acc;
      end
      result_q.push_back(res);
      parse_phase = PH_X;
      chunk_len   = 0;
      num_acc     = '0;
      num_done    = 1'b0;
      x_hold      = '0;
      y_hold      = '0;
      dir_acc     = '0;
      func_acc    = '0;
      ovl_acc     = '0;
      rec_failed  = 1'b0;
      slot_hold   = '0;
      rec_open    = 1'b0;
    end else if (!rec_failed) begin
      if (parse_phase != PH_COLOR && ch == ((parse_phase == PH_X) ? ChComma : ChColon)) begin
        if (parse_phase == PH_X) begin
          x_hold = num_acc;
        end else if (parse_phase == PH_Y) begin
          y_hold = num_acc;
        end
        parse_phase = phase_e'(parse_phase + 3'd1);
        chunk_len   = 0;
        num_acc     = '0;
        num_done    = 1'b0;
      end else if (chunk_len >= ChunkMax) begin
        rec_failed = 1'b1;
      end else begin
        chunk_len++;
        case (parse_phase)
          PH_DIRS: begin
            for (int i = 0; i < 6; i++) begin
              if (DirChars[8*(5-i) +: 8] == ch) dir_acc[i] = 1'b1;
            end
          end
          PH_FUNCS: begin
            for (int i = 0; i < 7; i++) begin
              if (FuncChars[8*(6-i) +: 8] == ch) func_acc = FuncW'(i);
            end
            for (int i = 0; i < 6; i++) begin
              if (OvlChars[8*(5-i) +: 8] == ch) ovl_acc[i] = 1'b1;
            end
          end
          default: begin
            if (!num_done) begin
              if (ch < ChZero || ch > ChNine) begin
                num_done = 1'b1;
              end else begin
                v       = int'(num_acc) * 10 + int'(ch - ChZero);
                num_acc = (v > 255) ? 8'hFF : ByteW'(v);
              end
            end
          end
        endcase
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : monitor
    led_result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        beat_taken = 1'b1;
        beats_taken++;
        parse_char(s_axis_tdata[7:0], s_axis_tdata[15:8]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result, slot", m_axis_tdata[7:0], 0);
        end else begin
          want = result_q.pop_front();
          if (m_axis_tuser !== want.ok)
            report_mismatch("ok", m_axis_tuser, want.ok);
          if (m_axis_tdata[7:0] !== want.slot)
            report_mismatch("slot", m_axis_tdata[7:0], want.slot);
          if (m_axis_tdata[15:8] !== want.pos_x)
            report_mismatch("pos_x", m_axis_tdata[15:8], want.pos_x);
          if (m_axis_tdata[23:16] !== want.pos_y)
            report_mismatch("pos_y", m_axis_tdata[23:16], want.pos_y);
          if (m_axis_tdata[29:24] !== want.dir_flags)
            report_mismatch("dir_flags", m_axis_tdata[29:24], want.dir_flags);
          if (m_axis_tdata[32:30] !== want.base_func)
            report_mismatch("base_func", m_axis_tdata[32:30], want.base_func);
          if (m_axis_tdata[38:33] !== want.overlay_bits)
            report_mismatch("overlay_bits", m_axis_tdata[38:33], want.overlay_bits);
          if (m_axis_tdata[46:39] !== want.color_index)
            report_mismatch("color_index", m_axis_tdata[46:39], want.color_index);
          if (m_axis_tdata[47] !== 1'b0)
            report_mismatch("pad bit", m_axis_tdata[47], 0);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || beat_taken) begin
        if (beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata  <= beat_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      beat_taken = 1'b0;
    end
  end

  function automatic logic [CharW-1:0] junk_char();
    return CharW'($urandom_range(255, 1));
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) rec_buf.push_back(s[i]);
  endtask

  task automatic add_digits(input int n);
    repeat (n) rec_buf.push_back(ChZero + CharW'($urandom_range(9)));
  endtask

  task automatic add_number();
    int r;
    r = $urandom_range(99);
    if (r < 60) begin
      add_digits($urandom_range(3));
    end else if (r < 80) begin
      add_digits($urandom_range(10, 4));
    end else if (r < 90) begin
      add_digits($urandom_range(2));
      rec_buf.push_back(junk_char());
      add_digits($urandom_range(3));
    end else begin
      add_digits($urandom_range(12, 9));
    end
  endtask

  task automatic add_letters(input logic is_funcs);
    int n;
    int r;
    n = ($urandom_range(99) < 90) ? $urandom_range(6) : $urandom_range(12, 7);
    repeat (n) begin
      r = $urandom_range(99);
      if (!is_funcs && r < 85)
        rec_buf.push_back(DirChars[8*$urandom_range(5) +: 8]);
      else if (is_funcs && r < 45)
        rec_buf.push_back(FuncChars[8*$urandom_range(6) +: 8]);
      else if (is_funcs && r < 85)
        rec_buf.push_back(OvlChars[8*$urandom_range(5) +: 8]);
      else
        rec_buf.push_back(junk_char());
    end
  endtask

  task automatic add_sep(input logic [CharW-1:0] sep);
    rec_buf.push_back(($urandom_range(99) < 4) ? junk_char() : sep);
  endtask

  task automatic flush_record(input logic [ByteW-1:0] idx);
    rec_buf.push_back(ChTerm);
    foreach (rec_buf[i]) begin
      beat_q.push_back({(i == 0) ? idx : ByteW'($urandom_range(255)), rec_buf[i]});
    end
    beats_pushed += rec_buf.size();
    rec_buf.delete();
  endtask

  task automatic make_record();
    int kind;
    int cut;
    int r;
    kind = $urandom_range(99);
    if (kind < 82) begin
      add_number();
      add_sep(ChComma);
      add_number();
      add_sep(ChColon);
      add_letters(1'b0);
      add_sep(ChColon);
      add_letters(1'b1);
      add_sep(ChColon);
      r = $urandom_range(99);
      if (r < 50) begin
        add_digits(1);
      end else if (r < 85) begin
        rec_buf.push_back(ChZero + CharW'($urandom_range(2, 1)));
        add_digits(1);
      end else begin
        add_number();
      end
      if (kind >= 74) begin
        cut = $urandom_range(rec_buf.size());
        while (rec_buf.size() > cut) void'(rec_buf.pop_back());
      end
    end else begin
      repeat ($urandom_range(14)) rec_buf.push_back(junk_char());
    end
    flush_record(($urandom_range(99) < 80) ? ByteW'($urandom_range(MaxLeds - 1))
                                           : ByteW'($urandom_range(255)));
  endtask

  initial begin
    int phase_base;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = SendIdlePct[p];
      recv_stall_pct = RecvStallPct[p];
      if (p == 0) begin
        flush_record(8'd0);
        add_text("9,7:N:C:1");
        flush_record(8'd31);
        add_text(",:::");
        flush_record(8'd32);
        add_text("999,:D:RW:15");
        flush_record(8'd5);
      end
      phase_base = beats_pushed;
      while (beats_pushed - phase_base < BeatsPerPhase) make_record();
      while (beats_taken != beats_pushed || result_q.size() != 0) @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: led_config_text_parser_top.f
hdl/lctp_pkg.sv
hdl/lctp_char_decode.sv
hdl/lctp_parser.sv
hdl/led_config_text_parser_top.sv
verif/led_config_text_parser_top_test.sv
